/* design/cml_pkg.sv */
// Shared constants and types for the complex magnitude to luma block.
package cml_pkg;

   localparam int LANES               = 4;
   localparam int SAMPLE_BITS_DEFAULT = 24;
   localparam int PIX_BITS            = 8;
   localparam int LOG2_BITS           = 4;

   localparam logic [LOG2_BITS-1:0] LOG2_COUNT_RESET = 4'd12;
   localparam logic [PIX_BITS-1:0]  LUMA_MAX         = 8'd255;

   typedef logic [PIX_BITS-1:0]           pix_type;
   typedef pix_type [LANES-1:0]           pix_word_type;
   typedef logic [LOG2_BITS-1:0]          log2_type;

endpackage

/* design/cml_intf.sv */
// Stream interfaces: sample word in, packed pixel word out.
interface cml_req_if
   import cml_pkg::*;
   #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT)
   ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] re0;
   logic signed [SAMPLE_BITS-1:0] im0;
   logic signed [SAMPLE_BITS-1:0] re1;
   logic signed [SAMPLE_BITS-1:0] im1;
   logic signed [SAMPLE_BITS-1:0] re2;
   logic signed [SAMPLE_BITS-1:0] im2;
   logic signed [SAMPLE_BITS-1:0] re3;
   logic signed [SAMPLE_BITS-1:0] im3;

   modport source (output valid, re0, im0, re1, im1, re2, im2, re3, im3, input ready);
   modport sink   (input valid, re0, im0, re1, im1, re2, im2, re3, im3, output ready);
endinterface

interface cml_rsp_if
   import cml_pkg::*;
   ();
   logic    valid;
   logic    ready;
   pix_type pix0;
   pix_type pix1;
   pix_type pix2;
   pix_type pix3;

   modport source (output valid, pix0, pix1, pix2, pix3, input ready);
   modport sink   (input valid, pix0, pix1, pix2, pix3, output ready);
endinterface

/* design/cml_square.sv */
// Front end: absolute value, squares and sum of squares, three stages.
module cml_square
   import cml_pkg::*;
   #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
     localparam int SUM_BITS   = 2 * SAMPLE_BITS + 2)
   (input  logic                                 clock,
    input  logic                                 reset,
    input  logic                                 advance,
    input  logic                                 in_valid,
    input  logic [LANES-1:0][SAMPLE_BITS-1:0]    re,
    input  logic [LANES-1:0][SAMPLE_BITS-1:0]    im,
    output logic                                 out_valid,
    output logic [LANES-1:0][SUM_BITS-1:0]       sum);

   localparam int SQ_BITS = 2 * SAMPLE_BITS;

   logic [2:0]                           valid_ff;
   logic [2:0]                           valid_in;
   logic [LANES-1:0][SAMPLE_BITS-1:0]    mag_re_ff, mag_im_ff, mag_re_in, mag_im_in;
   logic [LANES-1:0][SQ_BITS-1:0]        sq_re_ff, sq_im_ff, sq_re_in, sq_im_in;
   logic [LANES-1:0][SUM_BITS-1:0]       sum_ff, sum_in;

   // Stage logic: magnitude, square, add
   always_comb begin
      valid_in = {valid_ff[1:0], in_valid};
      for (int k = 0; k < LANES; k++) begin
         // most negative value maps to 2^(SAMPLE_BITS-1), still fits unsigned
         mag_re_in[k] = re[k][SAMPLE_BITS-1] ? (~re[k] + 1'b1) : re[k];
         mag_im_in[k] = im[k][SAMPLE_BITS-1] ? (~im[k] + 1'b1) : im[k];
         sq_re_in[k]  = mag_re_ff[k] * mag_re_ff[k];
         sq_im_in[k]  = mag_im_ff[k] * mag_im_ff[k];
         sum_in[k]    = SUM_BITS'(sq_re_ff[k]) + SUM_BITS'(sq_im_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_re_ff <= mag_re_in;
         mag_im_ff <= mag_im_in;
         sq_re_ff  <= sq_re_in;
         sq_im_ff  <= sq_im_in;
         sum_ff    <= sum_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign sum       = sum_ff;

endmodule

/* design/cml_sqrt.sv */
// Pipelined restoring square root, up to two root bits per stage, all lanes.
module cml_sqrt
   import cml_pkg::*;
   #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
     localparam int ROOT_BITS  = SAMPLE_BITS + 1,
     localparam int SUM_BITS   = 2 * ROOT_BITS)
   (input  logic                                 clock,
    input  logic                                 reset,
    input  logic                                 advance,
    input  logic                                 in_valid,
    input  logic [LANES-1:0][SUM_BITS-1:0]       sum,
    output logic                                 out_valid,
    output logic [LANES-1:0][ROOT_BITS-1:0]      root);

   localparam int REM_BITS = ROOT_BITS + 2;
   localparam int STAGES   = (ROOT_BITS + 1) / 2;

   logic [STAGES-1:0]                    valid_ff;
   logic [LANES-1:0][SUM_BITS-1:0]       rad_ff  [STAGES];
   logic [LANES-1:0][REM_BITS-1:0]       rem_ff  [STAGES];
   logic [LANES-1:0][ROOT_BITS-1:0]      root_ff [STAGES];

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      logic                              valid_prev;
      logic [LANES-1:0][SUM_BITS-1:0]    rad_prev, rad_in;
      logic [LANES-1:0][REM_BITS-1:0]    rem_prev, rem_in;
      logic [LANES-1:0][ROOT_BITS-1:0]   root_prev, root_in;

      // first stage starts from the radicand with empty root and remainder
      if (g == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rad_prev   = sum;
         assign rem_prev   = '0;
         assign root_prev  = '0;
      end else begin : g_next
         assign valid_prev = valid_ff[g-1];
         assign rad_prev   = rad_ff[g-1];
         assign rem_prev   = rem_ff[g-1];
         assign root_prev  = root_ff[g-1];
      end

      // up to two trial-subtract steps, each brings down two radicand bits
      always_comb begin
         for (int k = 0; k < LANES; k++) begin
            logic [SUM_BITS-1:0]  rad_c;
            logic [REM_BITS-1:0]  rem_c;
            logic [REM_BITS-1:0]  trial_c;
            logic [ROOT_BITS-1:0] root_c;
            rad_c   = rad_prev[k];
            rem_c   = rem_prev[k];
            root_c  = root_prev[k];
            trial_c = '0;
            for (int t = 0; t < 2; t++) begin
               if (2 * g + t < ROOT_BITS) begin
                  rem_c   = {rem_c[REM_BITS-3:0], rad_c[SUM_BITS-1 -: 2]};
                  rad_c   = {rad_c[SUM_BITS-3:0], 2'b00};
                  trial_c = {root_c, 2'b01};
                  if (rem_c >= trial_c) begin
                     rem_c  = rem_c - trial_c;
                     root_c = {root_c[ROOT_BITS-2:0], 1'b1};
                  end else begin
                     root_c = {root_c[ROOT_BITS-2:0], 1'b0};
                  end
               end
            end
            rad_in[k]  = rad_c;
            rem_in[k]  = rem_c;
            root_in[k] = root_c;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (advance) begin
            valid_ff[g] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[g]  <= rad_in;
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign root      = root_ff[STAGES-1];

endmodule

/* design/cml_scale.sv */
// Back end: shift by log2 count, clamp to a byte, output register and skid.
module cml_scale
   import cml_pkg::*;
   #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
     localparam int ROOT_BITS  = SAMPLE_BITS + 1)
   (input  logic                                 clock,
    input  logic                                 reset,
    input  logic                                 in_valid,
    input  logic [LANES-1:0][ROOT_BITS-1:0]      root,
    input  log2_type                             log2_count,
    output logic                                 advance,
    cml_rsp_if.source                            rsp);

   logic         tail_valid_ff, tail_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   pix_word_type tail_pix_ff, tail_pix_in;
   pix_word_type skid_pix_ff;
   pix_word_type out_pix;

   // pipeline moves whenever the skid stage is empty
   assign advance = !skid_valid_ff;

   // shift and clamp
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         logic [ROOT_BITS-1:0] shifted;
         shifted = root[k] >> log2_count;
         tail_pix_in[k] = (shifted > ROOT_BITS'(LUMA_MAX)) ? LUMA_MAX
                                                           : shifted[PIX_BITS-1:0];
      end
   end

   // tail/skid occupancy
   always_comb begin
      tail_valid_in = tail_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (advance) begin
         tail_valid_in = in_valid;
         skid_valid_in = tail_valid_ff && !rsp.ready;
      end else if (rsp.ready) begin
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         tail_valid_ff <= tail_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tail_pix_ff <= tail_pix_in;
         skid_pix_ff <= tail_pix_ff;
      end
   end

   // skid word goes first, it is the older one
   assign out_pix   = skid_valid_ff ? skid_pix_ff : tail_pix_ff;
   assign rsp.valid = skid_valid_ff || tail_valid_ff;
   assign rsp.pix0  = out_pix[0];
   assign rsp.pix1  = out_pix[1];
   assign rsp.pix2  = out_pix[2];
   assign rsp.pix3  = out_pix[3];

   // tail holds while the skid stage is full
   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(tail_valid_ff) && $stable(tail_pix_ff))
      else $error("tail word changed while skid full");

   // skid fills only from a tail word that was refused
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(tail_valid_ff && !rsp.ready))
      else $error("skid filled without a refused word");

   // a refused skid word stays
   a_skid_keep: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp.ready |=> skid_valid_ff && $stable(skid_pix_ff))
      else $error("skid word dropped while stalled");

endmodule

/* design/complex_magnitude_to_luma_top.sv */
// Top level: complex magnitude to luma quantizer, four lanes per word.
//
//   port              dir   handshake      word
//   req_word          in    valid/ready    re0..re3, im0..im3 (signed, 8 frac bits)
//   rsp_word          out   valid/ready    pix0..pix3 (one byte pixel per lane)
//   csr_write_*       in    write enable   log2_count (4 bits)
//
// One word accepted per cycle while the skid stage is empty; a word passes the three
// magnitude stages, the square root stages (up to two root bits each) and the
// output register.
// Reset clears all valid bits and sets log2_count to 12.
// A stall on rsp_word is absorbed by a one-word skid stage; req_word.ready is low
// while the skid holds a word and comes from a register.
module complex_magnitude_to_luma_top
   import cml_pkg::*;
   #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT)
   (input  logic                 clock,
    input  logic                 reset,
    input  logic                 csr_write_enable,
    input  log2_type             csr_write_data,
    cml_req_if.sink              req_word,
    cml_rsp_if.source            rsp_word);

   localparam int ROOT_BITS = SAMPLE_BITS + 1;
   localparam int SUM_BITS  = 2 * ROOT_BITS;

   log2_type                          log2_count_ff;
   logic                              advance;
   logic [LANES-1:0][SAMPLE_BITS-1:0] re_lane, im_lane;
   logic                              sum_valid, root_valid;
   logic [LANES-1:0][SUM_BITS-1:0]    sum_lane;
   logic [LANES-1:0][ROOT_BITS-1:0]   root_lane;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         log2_count_ff <= LOG2_COUNT_RESET;
      end else if (csr_write_enable) begin
         log2_count_ff <= csr_write_data;
      end
   end

   // lane unpack
   assign re_lane[0] = req_word.re0;
   assign im_lane[0] = req_word.im0;
   assign re_lane[1] = req_word.re1;
   assign im_lane[1] = req_word.im1;
   assign re_lane[2] = req_word.re2;
   assign im_lane[2] = req_word.im2;
   assign re_lane[3] = req_word.re3;
   assign im_lane[3] = req_word.im3;

   assign req_word.ready = advance;

   cml_square #(.SAMPLE_BITS(SAMPLE_BITS)) u_square (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_word.valid),
      .re        (re_lane),
      .im        (im_lane),
      .out_valid (sum_valid),
      .sum       (sum_lane));

   cml_sqrt #(.SAMPLE_BITS(SAMPLE_BITS)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sum_valid),
      .sum       (sum_lane),
      .out_valid (root_valid),
      .root      (root_lane));

   cml_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (root_valid),
      .root       (root_lane),
      .log2_count (log2_count_ff),
      .advance    (advance),
      .rsp        (rsp_word));

endmodule
